// ===== sv/chrt_pkg.sv =====
package chrt_pkg;

    // Width of every byte offset, length and size.
    localparam int IDX_W = 16;

    // Default depth of the hole table.
    localparam int DEFAULT_MAX_HOLES = 16;

    // Request kinds carried in req_type.
    localparam logic REQ_CHUNK = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_OUT_RANGE = 3'd3,
        ST_COPY_FAIL = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // One incoming request.
    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] seg_bytes;
        logic [IDX_W-1:0] query_end_index;
        logic             transfer_ok;
    } req_t;

    // One result.
    typedef struct packed {
        status_t status;
        logic    range_covered;
        logic    payload_complete;
    } res_t;

    // One hole, the half-open range [hbegin, hfinish).
    typedef struct packed {
        logic [IDX_W-1:0] hbegin;
        logic [IDX_W-1:0] hfinish;
    } hole_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan;
        logic decide;
        logic write_right;
        logic write_left;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic write_right;
        logic write_left;
        logic out_free;
        logic slot_a_found;
        logic slot_b_found;
    } ctrl_sts_t;

endpackage

// ===== sv/chrt_ctrl.sv =====
module chrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chrt_pkg::ctrl_sts_t  sts,
    output chrt_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        FLUSH,
        DECIDE,
        WR_RIGHT,
        WR_LEFT,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic for the request sequence.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                if (sts.scan_last) begin
                    state_next = FLUSH;
                end
            end
            FLUSH: begin
                state_next = DECIDE;
            end
            DECIDE: begin
                if (sts.write_right) begin
                    state_next = WR_RIGHT;
                end else if (sts.write_left) begin
                    state_next = WR_LEFT;
                end else begin
                    state_next = RESULT;
                end
            end
            WR_RIGHT: begin
                if (sts.write_left) begin
                    state_next = WR_LEFT;
                end else begin
                    state_next = RESULT;
                end
            end
            WR_LEFT: begin
                state_next = RESULT;
            end
            RESULT: begin
                if (sts.out_free) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // Command decode from the current state and the handshake inputs.
    always_comb begin
        s_ready         = (state_reg == IDLE);
        cmd             = '0;
        cmd.load_req    = (state_reg == IDLE) && s_valid;
        cmd.scan        = (state_reg == SCAN);
        cmd.decide      = (state_reg == DECIDE);
        cmd.write_right = (state_reg == WR_RIGHT);
        cmd.write_left  = (state_reg == WR_LEFT);
        cmd.load_out    = (state_reg == RESULT) && sts.out_free;
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/chrt_dp.sv =====
module chrt_dp #(
    parameter int MAX_HOLES = chrt_pkg::DEFAULT_MAX_HOLES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  chrt_pkg::ctrl_cmd_t         cmd,
    output chrt_pkg::ctrl_sts_t         sts,
    input  chrt_pkg::req_t              s_data,
    input  logic                        cfg_wr_en,
    input  logic [chrt_pkg::IDX_W-1:0]  cfg_wr_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output chrt_pkg::res_t              m_data
);

    localparam int IW = $clog2(MAX_HOLES);
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int RW = CW + 1;
    localparam int XW = chrt_pkg::IDX_W;

    // Hole table storage.
    chrt_pkg::hole_t mem [MAX_HOLES];

    // Control state.
    logic [XW-1:0]        size_reg;
    logic                 init_reg;
    logic                 done_reg;
    logic [MAX_HOLES-1:0] valid_reg;
    logic                 rd_pend_reg;
    logic                 m_valid_reg;

    // Captured request.
    logic                 is_query_reg;
    logic [XW-1:0]        lo_reg;
    logic [XW:0]          hi_reg;
    logic                 len_zero_reg;
    logic                 ok_reg;

    // Scan pointer and read pipeline.
    logic [IW-1:0]        addr_reg;
    logic [IW-1:0]        rd_idx_reg;
    chrt_pkg::hole_t      rd_entry_reg;

    // Scan accumulators.
    logic                 covered_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        cut_reg;
    logic [MAX_HOLES-1:0] cut_mask_reg;
    logic                 has_left_reg;
    logic                 has_right_reg;
    logic [XW-1:0]        lb_reg;
    logic [XW-1:0]        rf_reg;
    logic [IW-1:0]        slot_a_reg;
    logic [IW-1:0]        slot_b_reg;
    logic                 slot_a_found_reg;
    logic                 slot_b_found_reg;

    // Result staging.
    chrt_pkg::status_t    res_status_reg;
    chrt_pkg::res_t       m_data_reg;

    // Combinational signals.
    logic [XW-1:0]        ent_b;
    logic [XW-1:0]        ent_f;
    logic                 ent_v;
    logic                 ent_ov;
    logic [RW-1:0]        remaining;
    logic                 overflow;
    logic                 oob;
    logic                 commit_ok;
    chrt_pkg::status_t    status_next;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    chrt_pkg::hole_t      wr_data;

    // Entry under evaluation; entry 0 reads as the full hole until first written.
    always_comb begin
        if (init_reg && (rd_idx_reg == '0)) begin
            ent_b = '0;
            ent_f = size_reg;
        end else begin
            ent_b = rd_entry_reg.hbegin;
            ent_f = rd_entry_reg.hfinish;
        end
        ent_v  = valid_reg[rd_idx_reg];
        ent_ov = ent_v && (hi_reg > {1'b0, ent_b}) && (lo_reg < ent_f);
    end

    // Outcome of the scan: hole count after the cut and the status code.
    always_comb begin
        remaining = RW'(count_reg) - RW'(cut_reg) + RW'(has_left_reg) + RW'(has_right_reg);
        overflow  = remaining > RW'(MAX_HOLES);
        oob       = hi_reg > {1'b0, size_reg};
        commit_ok = !is_query_reg && !len_zero_reg && !oob && ok_reg && !overflow;
        if (is_query_reg) begin
            status_next = chrt_pkg::ST_ACCEPTED;
        end else if (len_zero_reg) begin
            status_next = chrt_pkg::ST_EMPTY;
        end else if (oob) begin
            status_next = chrt_pkg::ST_OUT_RANGE;
        end else if (!ok_reg) begin
            status_next = chrt_pkg::ST_COPY_FAIL;
        end else if (overflow) begin
            status_next = chrt_pkg::ST_FULL;
        end else if (remaining == '0) begin
            status_next = chrt_pkg::ST_COMPLETE;
        end else begin
            status_next = chrt_pkg::ST_ACCEPTED;
        end
    end

    // Right piece to the first free slot; left to the next, or the first if alone.
    always_comb begin
        wr_en = cmd.write_right || cmd.write_left;
        if (cmd.write_left) begin
            wr_addr        = has_right_reg ? slot_b_reg : slot_a_reg;
            wr_data.hbegin  = lb_reg;
            wr_data.hfinish = lo_reg;
        end else begin
            wr_addr        = slot_a_reg;
            wr_data.hbegin  = hi_reg[XW-1:0];
            wr_data.hfinish = rf_reg;
        end
    end

    // Status toward the controller.
    always_comb begin
        sts              = '0;
        sts.scan_last    = (addr_reg == IW'(MAX_HOLES - 1));
        sts.write_right  = commit_ok && has_right_reg;
        sts.write_left   = commit_ok && has_left_reg;
        sts.out_free     = !m_valid_reg || m_ready;
        sts.slot_a_found = slot_a_found_reg;
        sts.slot_b_found = slot_b_found_reg;
    end

    // Table memory: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan) begin
            rd_entry_reg <= mem[addr_reg];
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= '0;
            init_reg    <= 1'b1;
            done_reg    <= 1'b0;
            valid_reg   <= MAX_HOLES'(1);
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A size write restarts tracking with one full hole.
            if (cfg_wr_en) begin
                size_reg  <= cfg_wr_data;
                init_reg  <= 1'b1;
                done_reg  <= 1'b0;
                valid_reg <= MAX_HOLES'(1);
            end
            rd_pend_reg <= cmd.scan;
            // Drop every hole the chunk overlapped.
            if (cmd.decide && commit_ok) begin
                valid_reg <= valid_reg & ~cut_mask_reg;
                if (remaining == '0) begin
                    done_reg <= 1'b1;
                end
            end
            // Mark a placed remainder as live.
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
                if (wr_addr == '0) begin
                    init_reg <= 1'b0;
                end
            end
            // Output register handshake.
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan accumulators and result staging.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            is_query_reg     <= (s_data.req_type == chrt_pkg::REQ_QUERY);
            lo_reg           <= s_data.start_index;
            if (s_data.req_type == chrt_pkg::REQ_QUERY) begin
                hi_reg <= {1'b0, s_data.query_end_index};
            end else begin
                hi_reg <= {1'b0, s_data.start_index} + {1'b0, s_data.seg_bytes};
            end
            len_zero_reg     <= (s_data.seg_bytes == '0);
            ok_reg           <= s_data.transfer_ok;
            addr_reg         <= '0;
            covered_reg      <= 1'b1;
            count_reg        <= '0;
            cut_reg          <= '0;
            cut_mask_reg     <= '0;
            has_left_reg     <= 1'b0;
            has_right_reg    <= 1'b0;
            slot_a_found_reg <= 1'b0;
            slot_b_found_reg <= 1'b0;
        end
        if (cmd.scan) begin
            addr_reg   <= addr_reg + IW'(1);
            rd_idx_reg <= addr_reg;
        end
        // One hole entry is evaluated per cycle.
        if (rd_pend_reg) begin
            if (ent_v) begin
                count_reg <= count_reg + CW'(1);
            end
            if (ent_ov) begin
                covered_reg              <= 1'b0;
                cut_reg                  <= cut_reg + CW'(1);
                cut_mask_reg[rd_idx_reg] <= 1'b1;
                if (lo_reg > ent_b) begin
                    has_left_reg <= 1'b1;
                    lb_reg       <= ent_b;
                end
                if (hi_reg < {1'b0, ent_f}) begin
                    has_right_reg <= 1'b1;
                    rf_reg        <= ent_f;
                end
            end
            // Remember the first two slots that are free once the cut is applied.
            if (!ent_v || ent_ov) begin
                if (!slot_a_found_reg) begin
                    slot_a_reg       <= rd_idx_reg;
                    slot_a_found_reg <= 1'b1;
                end else if (!slot_b_found_reg) begin
                    slot_b_reg       <= rd_idx_reg;
                    slot_b_found_reg <= 1'b1;
                end
            end
        end
        if (cmd.decide) begin
            res_status_reg <= status_next;
        end
        if (cmd.load_out) begin
            m_data_reg.status           <= res_status_reg;
            m_data_reg.range_covered    <= is_query_reg && covered_reg;
            m_data_reg.payload_complete <= done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/chunk_reassembly_hole_tracker.sv =====
// A result follows a walk over the hole table at one entry per cycle, then up to two
// remainder writes through the single table write port, and is registered on m_data.
// Requests do not overlap: a new one is accepted only once the previous result is loaded
// into the output register, which waits while an earlier result still waits for m_ready.
// Reset (aresetn low, synchronous): size 0, one empty hole, not complete, no result pending.
module chunk_reassembly_hole_tracker #(
    parameter int MAX_HOLES = chrt_pkg::DEFAULT_MAX_HOLES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  chrt_pkg::req_t              s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output chrt_pkg::res_t              m_data,
    input  logic                        cfg_wr_en,
    input  logic [chrt_pkg::IDX_W-1:0]  cfg_wr_data
);

    chrt_pkg::ctrl_cmd_t cmd;
    chrt_pkg::ctrl_sts_t sts;

    // Request sequencer.
    chrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hole table and scan datapath.
    chrt_dp #(
        .MAX_HOLES (MAX_HOLES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef SYNTHESIS
    // A request keeps the block busy for the whole table walk.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the previous one was still in work");

    // The table-full check guarantees a free slot for every remainder.
    a_right_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.write_right |-> sts.slot_a_found)
        else $error("right remainder without a free slot");

    // Once the walk is over, two remainders always find two free slots.
    a_two_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide && sts.write_right && sts.write_left |-> sts.slot_b_found)
        else $error("two remainders without two free slots");

    // A completing chunk must report the payload complete.
    a_complete_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == chrt_pkg::ST_COMPLETE) |-> m_data.payload_complete)
        else $error("complete status without the completion flag");
`endif

endmodule
